>>> rtl/olid_pkg.sv
// Shared types and constants for the operand-latched integer divider.
// No dependencies; imported by every module of the block.
package olid_pkg;

   localparam int WIDTH_DEFAULT = 32;
   localparam int FIELD_WIDTH   = 32;
   localparam int QUEUE_DEPTH   = 2;

   // req_type codes
   localparam logic REQ_DIVIDEND = 1'b0;
   localparam logic REQ_DIVISOR  = 1'b1;

   typedef struct packed {
      logic neg_q;
      logic neg_r;
      logic unknown;
   } olid_flags_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FIXUP,
      ST_HOLD
   } olid_state_type;

endpackage

>>> rtl/olid_front.sv
// Front end: holds both operands and the mode register, classifies each beat.
// Depends on olid_pkg.
module olid_front #(
   parameter int WIDTH = olid_pkg::WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_signed_mode,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_type,
   input  logic [olid_pkg::FIELD_WIDTH-1:0]    req_operand_value,
   input  logic                                req_operand_unknown,
   input  logic                                queue_full,
   output logic                                push,
   output logic [WIDTH-1:0]                    job_a,
   output logic [WIDTH-1:0]                    job_b,
   output olid_pkg::olid_flags_type            job_flags
);
   import olid_pkg::*;

   logic             signed_mode_ff;
   logic [WIDTH-1:0] dividend_ff, dividend_in;
   logic [WIDTH-1:0] divisor_ff, divisor_in;
   logic             dividend_unk_ff, dividend_unk_in;
   logic             divisor_unk_ff, divisor_unk_in;
   logic [WIDTH-1:0] value;
   logic             sign_a, sign_b;

   assign csr_ready = 1'b1;
   assign req_stall = queue_full;
   assign push      = req_valid && !req_stall;
   assign value     = WIDTH'(req_operand_value);

   always_comb begin
      dividend_in     = dividend_ff;
      divisor_in      = divisor_ff;
      dividend_unk_in = dividend_unk_ff;
      divisor_unk_in  = divisor_unk_ff;
      if (req_type == REQ_DIVIDEND) begin
         dividend_in     = value;
         dividend_unk_in = req_operand_unknown;
      end else begin
         divisor_in      = value;
         divisor_unk_in  = req_operand_unknown;
      end
   end

   // classify against the pair as it stands after this beat
   always_comb begin
      sign_a            = signed_mode_ff && dividend_in[WIDTH-1];
      sign_b            = signed_mode_ff && divisor_in[WIDTH-1];
      job_a             = sign_a ? (~dividend_in + 1'b1) : dividend_in;
      job_b             = sign_b ? (~divisor_in + 1'b1) : divisor_in;
      job_flags.neg_q   = sign_a ^ sign_b;
      job_flags.neg_r   = sign_a;
      job_flags.unknown = dividend_unk_in || divisor_unk_in || (divisor_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         signed_mode_ff  <= 1'b0;
         dividend_ff     <= '0;
         divisor_ff      <= '0;
         dividend_unk_ff <= 1'b1;
         divisor_unk_ff  <= 1'b1;
      end else begin
         if (csr_valid && csr_ready)
            signed_mode_ff <= csr_signed_mode;
         if (push) begin
            dividend_ff     <= dividend_in;
            divisor_ff      <= divisor_in;
            dividend_unk_ff <= dividend_unk_in;
            divisor_unk_ff  <= divisor_unk_in;
         end
      end
   end

endmodule

>>> rtl/olid_queue.sv
// Small FIFO of classified jobs between front and back.
// Depends on olid_pkg for the default depth.
module olid_queue #(
   parameter int DATA_WIDTH = 8,
   parameter int DEPTH      = olid_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [DATA_WIDTH-1:0] push_data,
   input  logic                  pop,
   output logic [DATA_WIDTH-1:0] pop_data,
   output logic                  full,
   output logic                  not_empty
);
   import olid_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (do_pop && !do_push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

>>> rtl/olid_divider.sv
// Back end: radix-2 restoring divider with sign fix-up and output register.
// Depends on olid_pkg.
module olid_divider #(
   parameter int WIDTH = olid_pkg::WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             job_valid,
   output logic                             pop,
   input  logic [WIDTH-1:0]                 job_a,
   input  logic [WIDTH-1:0]                 job_b,
   input  olid_pkg::olid_flags_type         job_flags,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [olid_pkg::FIELD_WIDTH-1:0] rsp_quotient,
   output logic [olid_pkg::FIELD_WIDTH-1:0] rsp_remainder,
   output logic                             rsp_result_unknown
);
   import olid_pkg::*;

   localparam int CNT_W = $clog2(WIDTH);

   olid_state_type   state_ff, state_in;
   olid_flags_type   flags_ff;
   logic [WIDTH-1:0] divisor_ff;
   logic [WIDTH-1:0] quo_ff;
   logic [WIDTH-1:0] rem_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [WIDTH-1:0] quo_out_ff, rem_out_ff;
   logic             unk_out_ff;
   logic [WIDTH:0]   shifted, diff;
   logic             fits;

   // one quotient bit per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[WIDTH-1]};
      diff    = shifted - {1'b0, divisor_ff};
      fits    = !diff[WIDTH];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (job_valid) state_in = job_flags.unknown ? ST_FIXUP : ST_DIVIDE;
         ST_DIVIDE: if (cnt_ff == CNT_W'(WIDTH - 1)) state_in = ST_FIXUP;
         ST_FIXUP:  state_in = ST_HOLD;
         ST_HOLD:   if (!rsp_stall) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pop       = (state_ff == ST_IDLE) && job_valid;
      rsp_valid = (state_ff == ST_HOLD);
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               quo_ff     <= job_a;
               rem_ff     <= '0;
               divisor_ff <= job_b;
               flags_ff   <= job_flags;
               cnt_ff     <= '0;
            end
         end
         ST_DIVIDE: begin
            rem_ff <= fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
            quo_ff <= {quo_ff[WIDTH-2:0], fits};
            cnt_ff <= cnt_ff + 1'b1;
         end
         ST_FIXUP: begin
            unk_out_ff <= flags_ff.unknown;
            if (flags_ff.unknown) begin
               quo_out_ff <= '0;
               rem_out_ff <= '0;
            end else begin
               quo_out_ff <= flags_ff.neg_q ? (~quo_ff + 1'b1) : quo_ff;
               rem_out_ff <= flags_ff.neg_r ? (~rem_ff + 1'b1) : rem_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_quotient       = FIELD_WIDTH'(quo_out_ff);
   assign rsp_remainder      = FIELD_WIDTH'(rem_out_ff);
   assign rsp_result_unknown = unk_out_ff;

endmodule

>>> rtl/operand_latched_integer_divider.sv
// Operand-latched integer divider, top level: front end, job queue, divider back end.
// Depends on olid_pkg, olid_front, olid_queue, olid_divider.
//
// Each accepted req beat replaces the dividend or the divisor and yields one rsp beat
// with quotient, remainder and an unknown flag. The front end takes a beat in the
// cycle it arrives while the two-entry job queue has room, so up to two beats can be
// taken while the divider is busy or a result waits on rsp_stall. The divider is a
// radix-2 restoring loop retiring one quotient bit per cycle; an item passes through the
// back end as take from queue, WIDTH loop steps, sign fix-up and output beat; an item
// with an unknown operand or zero divisor skips the loop. Sustained rate is set by that
// loop. csr_signed_mode is always ready and should be written only while the block is idle.
module operand_latched_integer_divider #(
   parameter int WIDTH = olid_pkg::WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic                             csr_signed_mode,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_type,
   input  logic [olid_pkg::FIELD_WIDTH-1:0] req_operand_value,
   input  logic                             req_operand_unknown,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [olid_pkg::FIELD_WIDTH-1:0] rsp_quotient,
   output logic [olid_pkg::FIELD_WIDTH-1:0] rsp_remainder,
   output logic                             rsp_result_unknown
);
   import olid_pkg::*;

   localparam int FLAGS_W = $bits(olid_flags_type);
   localparam int JOB_W   = 2 * WIDTH + FLAGS_W;

   logic             push, pop, queue_full, queue_not_empty;
   logic [WIDTH-1:0] front_a, front_b, back_a, back_b;
   olid_flags_type   front_flags, back_flags;
   logic [JOB_W-1:0] push_data, pop_data;

   olid_front #(.WIDTH(WIDTH)) u_front (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_signed_mode     (csr_signed_mode),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_type            (req_type),
      .req_operand_value   (req_operand_value),
      .req_operand_unknown (req_operand_unknown),
      .queue_full          (queue_full),
      .push                (push),
      .job_a               (front_a),
      .job_b               (front_b),
      .job_flags           (front_flags)
   );

   assign push_data = {front_flags, front_a, front_b};

   olid_queue #(.DATA_WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (queue_full),
      .not_empty (queue_not_empty)
   );

   assign {back_flags, back_a, back_b} = pop_data;

   olid_divider #(.WIDTH(WIDTH)) u_divider (
      .clock              (clock),
      .reset              (reset),
      .job_valid          (queue_not_empty),
      .pop                (pop),
      .job_a              (back_a),
      .job_b              (back_b),
      .job_flags          (back_flags),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_quotient       (rsp_quotient),
      .rsp_remainder      (rsp_remainder),
      .rsp_result_unknown (rsp_result_unknown)
   );

endmodule

>>> test/tb_operand_latched_integer_divider.sv
// Testbench for operand_latched_integer_divider: directed and random operand updates,
// each result checked against a built-in divider model in both signed and unsigned mode.
// Depends on olid_pkg and the operand_latched_integer_divider RTL.
module tb_operand_latched_integer_divider;
   import olid_pkg::*;

   localparam int W          = WIDTH_DEFAULT;
   localparam int FW         = FIELD_WIDTH;
   localparam int IDLE_LIMIT = 4000;
   localparam int SETTLE     = 40;

   typedef struct packed {
      logic [FW-1:0] quotient;
      logic [FW-1:0] remainder;
      logic          unknown;
   } quot_rem_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic          csr_signed_mode = 1'b0;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic          req_type = REQ_DIVIDEND;
   logic [FW-1:0] req_operand_value = '0;
   logic          req_operand_unknown = 1'b0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [FW-1:0] rsp_quotient;
   logic [FW-1:0] rsp_remainder;
   logic          rsp_result_unknown;

   // model state, reset values of the block
   logic [W-1:0] held_dividend = '0;
   logic [W-1:0] held_divisor = '0;
   logic         dividend_unk = 1'b1;
   logic         divisor_unk = 1'b1;
   logic         mode_signed = 1'b0;

   quot_rem_type pending_results[$];
   int           error_count = 0;
   int           idle_cycles = 0;
   logic         steady = 1'b0;

   operand_latched_integer_divider dut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_signed_mode     (csr_signed_mode),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_type            (req_type),
      .req_operand_value   (req_operand_value),
      .req_operand_unknown (req_operand_unknown),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_quotient        (rsp_quotient),
      .rsp_remainder       (rsp_remainder),
      .rsp_result_unknown  (rsp_result_unknown)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Latch the new operand, then divide the held pair.
   function automatic quot_rem_type divide_held_pair(input logic kind,
                                                     input logic [FW-1:0] value,
                                                     input logic unk);
      quot_rem_type res;
      logic [W-1:0] mag_a;
      logic [W-1:0] mag_b;
      logic [W-1:0] q;
      logic [W-1:0] r;
      logic         flip_q;
      logic         flip_r;
      if (kind == REQ_DIVIDEND) begin
         held_dividend = value[W-1:0];
         dividend_unk  = unk;
      end else begin
         held_divisor = value[W-1:0];
         divisor_unk  = unk;
      end
      mag_a  = held_dividend;
      mag_b  = held_divisor;
      flip_q = 1'b0;
      flip_r = 1'b0;
      if (mode_signed) begin
         if (mag_a[W-1]) begin
            mag_a  = '0 - mag_a;
            flip_q = 1'b1;
            flip_r = 1'b1;
         end
         if (mag_b[W-1]) begin
            mag_b  = '0 - mag_b;
            flip_q = !flip_q;
         end
      end
      res = '0;
      if (dividend_unk || divisor_unk || mag_b == '0) begin
         res.unknown = 1'b1;
      end else begin
         q = mag_a / mag_b;
         r = mag_a % mag_b;
         if (flip_q) q = '0 - q;
         if (flip_r) r = '0 - r;
         res.quotient  = FW'(q);
         res.remainder = FW'(r);
      end
      return res;
   endfunction

   function automatic logic [FW-1:0] pick_operand();
      case ($urandom_range(8))
         0: return '0;
         1: return 1;
         2: return '1;
         3: return {1'b1, {(FW-1){1'b0}}};
         4: return {1'b0, {(FW-1){1'b1}}};
         5: return FW'($urandom_range(15));
         6: return '0 - FW'($urandom_range(15));
         7: return FW'($urandom >> $urandom_range(31));
         default: return FW'($urandom);
      endcase
   endfunction

   // One req beat. Callers follow with another beat or wait_for_results in the same step.
   task automatic send_operand(input logic kind, input logic [FW-1:0] value, input logic unk);
      int gap;
      gap = 0;
      if (!steady) begin
         while ($urandom_range(99) < 18 && gap < 12) gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_type            <= kind;
      req_operand_value   <= value;
      req_operand_unknown <= unk;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(divide_held_pair(kind, value, unk));
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_signed_mode(input logic m);
      wait_for_results();
      repeat (4) @(posedge clock);
      csr_valid       <= 1'b1;
      csr_signed_mode <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      mode_signed = m;
      csr_valid <= 1'b0;
   endtask

   // both operands start unknown; a known divisor alone is not enough
   task automatic test_unknown_after_reset();
      send_operand(REQ_DIVISOR, 7, 1'b0);
      send_operand(REQ_DIVIDEND, 100, 1'b0);
      wait_for_results();
   endtask

   task automatic test_unsigned_division();
      write_signed_mode(1'b0);
      send_operand(REQ_DIVISOR, 0, 1'b0);
      send_operand(REQ_DIVISOR, '1, 1'b0);
      send_operand(REQ_DIVIDEND, '1, 1'b0);
      send_operand(REQ_DIVIDEND, 0, 1'b0);
      send_operand(REQ_DIVISOR, 1, 1'b0);
      send_operand(REQ_DIVIDEND, '1, 1'b0);
      send_operand(REQ_DIVIDEND, 5, 1'b1);
      send_operand(REQ_DIVIDEND, 32'h8000_0000, 1'b0);
      send_operand(REQ_DIVISOR, '1, 1'b0);
      wait_for_results();
   endtask

   task automatic test_signed_division();
      write_signed_mode(1'b1);
      // most negative over minus one wraps to itself
      send_operand(REQ_DIVIDEND, 32'h8000_0000, 1'b0);
      send_operand(REQ_DIVISOR, '1, 1'b0);
      send_operand(REQ_DIVIDEND, -32'sd7, 1'b0);
      send_operand(REQ_DIVISOR, 2, 1'b0);
      send_operand(REQ_DIVISOR, -32'sd2, 1'b0);
      send_operand(REQ_DIVIDEND, 7, 1'b0);
      send_operand(REQ_DIVISOR, 0, 1'b0);
      send_operand(REQ_DIVISOR, 32'h8000_0000, 1'b0);
      send_operand(REQ_DIVIDEND, 32'h7FFF_FFFF, 1'b0);
      send_operand(REQ_DIVIDEND, 32'h8000_0000, 1'b0);
      send_operand(REQ_DIVISOR, 3, 1'b1);
      send_operand(REQ_DIVISOR, 3, 1'b0);
      wait_for_results();
   endtask

   task automatic test_random_operands(input int count, input logic m, input logic hold_mid);
      write_signed_mode(m);
      for (int i = 0; i < count; i++) begin
         if (hold_mid && i == count / 2) wait_for_results();
         send_operand(logic'($urandom_range(1)), pick_operand(), $urandom_range(99) < 8);
      end
      wait_for_results();
   endtask

   task automatic test_back_to_back(input int count);
      steady = 1'b1;
      test_random_operands(count, 1'b1, 1'b0);
      steady = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_unknown_after_reset();
      test_unsigned_division();
      test_signed_division();
      test_random_operands(400, 1'b0, 1'b1);
      test_random_operands(400, 1'b1, 1'b0);
      test_back_to_back(300);
      test_random_operands(350, 1'b0, 1'b0);
      wait_for_results();
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("tb_operand_latched_integer_divider OK");
      end else begin
         $display("tb_operand_latched_integer_divider NOT OK");
      end
      $finish;
   end

   // rsp side: random stall and compare each beat with the oldest expectation
   always @(posedge clock) begin : result_check
      quot_rem_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected rsp beat: q=%h r=%h unk=%b",
                           rsp_quotient, rsp_remainder, rsp_result_unknown);
            end else begin
               want = pending_results.pop_front();
               if (rsp_quotient !== want.quotient || rsp_remainder !== want.remainder ||
                   rsp_result_unknown !== want.unknown) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("rsp mismatch: exp q=%h r=%h unk=%b, got q=%h r=%h unk=%b",
                              want.quotient, want.remainder, want.unknown,
                              rsp_quotient, rsp_remainder, rsp_result_unknown);
               end
            end
         end
         rsp_stall <= !steady && ($urandom_range(99) < 18);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_operand_latched_integer_divider NOT OK");
            $finish;
         end
      end
   end

endmodule
